>>> hw/rtl/sabo_pkg.sv
package sabo_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int WORD_W      = 32;
	localparam int KIND_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_W     = 7;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MUL  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MOD  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic in_load;
		logic decode;
		logic exec;
		logic div_start;
		logic div_take;
		logic pop;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic bin_ok;
		logic divmod;
		logic div_done;
	} dp_stat_t;

endpackage

>>> hw/rtl/sabo_div.sv
module sabo_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sabo_pkg::WORD_W-1:0]       dividend,
	input  logic [sabo_pkg::WORD_W-1:0]       divisor,
	output logic                              done,
	output logic [sabo_pkg::WORD_W-1:0]       quotient,
	output logic [sabo_pkg::WORD_W-1:0]       remainder
);

	localparam int W      = sabo_pkg::WORD_W;
	localparam int STEP_W = $clog2(W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic [W-1:0]      dvs_q;
	logic              neg_q;
	logic              sgn_q;
	logic [W:0]        shifted;
	logic [W:0]        diff;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		mag = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag(dividend);
			dvs_q <= mag(divisor);
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
			sgn_q <= dividend[W-1];
		end else if (busy_q) begin
			rem_q <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done      = done_q;
	assign quotient  = neg_q ? (~quo_q + W'(1)) : quo_q;
	assign remainder = sgn_q ? (~rem_q + W'(1)) : rem_q;

endmodule

>>> hw/rtl/sabo_ctrl.sv
module sabo_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  sabo_pkg::dp_stat_t    stat,
	output sabo_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_DIVW   = 3'd3;
	localparam logic [2:0] S_APPLY  = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = stat.bin_ok ? S_EXEC : S_RESP;
			end
			S_EXEC: begin
				if (stat.divmod) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVW;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_APPLY;
				end
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.pop = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/sabo_dp.sv
module sabo_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sabo_pkg::ctrl_cmd_t                  cmd,
	output sabo_pkg::dp_stat_t                   stat,
	input  logic [sabo_pkg::KIND_W-1:0]          kind,
	input  logic signed [sabo_pkg::WORD_W-1:0]   push_value,
	output logic [sabo_pkg::STATUS_W-1:0]        status,
	output logic signed [sabo_pkg::WORD_W-1:0]   top_value,
	output logic [sabo_pkg::DEPTH_W-1:0]         depth
);

	localparam int W      = sabo_pkg::WORD_W;
	localparam int CNT_W  = sabo_pkg::CNT_W;
	localparam int ADDR_W = sabo_pkg::ADDR_W;
	localparam int DW     = sabo_pkg::DEPTH_W;

	logic [sabo_pkg::KIND_W-1:0]   kind_q;
	logic [W-1:0]                  push_q;
	logic [CNT_W-1:0]              count_q;
	logic [W-1:0]                  top_q;
	logic [W-1:0]                  second_q;
	logic [W-1:0]                  res_q;
	logic [sabo_pkg::STATUS_W-1:0] status_q;
	logic [sabo_pkg::STATUS_W-1:0] status_d;
	logic [sabo_pkg::STATUS_W-1:0] status_out_q;
	logic [W-1:0]                  top_out_q;
	logic [DW-1:0]                 depth_out_q;
	logic [W-1:0]                  mem [sabo_pkg::STACK_DEPTH];
	logic [CNT_W-1:0]              cnt_m1;
	logic [CNT_W-1:0]              cnt_m2;
	logic                          full;
	logic                          short;
	logic                          push_ok;
	logic [CNT_W+DW-1:0]           count_ext;
	logic [W-1:0]                  product;
	logic                          div_done;
	logic [W-1:0]                  quo;
	logic [W-1:0]                  rem;

	// the top of stack lives in top_q, the memory holds the entries below it
	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(2);
	assign full    = (count_q == CNT_W'(sabo_pkg::STACK_DEPTH));
	assign short   = (count_q < CNT_W'(2));
	assign push_ok = (kind_q == sabo_pkg::KIND_PUSH) && !full;

	always_comb begin
		case (kind_q)
			sabo_pkg::KIND_PUSH: status_d = full ? sabo_pkg::ST_FULL : sabo_pkg::ST_OK;
			sabo_pkg::KIND_ADD,
			sabo_pkg::KIND_SUB,
			sabo_pkg::KIND_MUL:  status_d = short ? sabo_pkg::ST_SHORT : sabo_pkg::ST_OK;
			sabo_pkg::KIND_DIV,
			sabo_pkg::KIND_MOD: begin
				if (short) begin
					status_d = sabo_pkg::ST_SHORT;
				end else if (top_q == '0) begin
					status_d = sabo_pkg::ST_DIVZERO;
				end else begin
					status_d = sabo_pkg::ST_OK;
				end
			end
			default: status_d = sabo_pkg::ST_OK;
		endcase
	end

	assign stat.bin_ok   = (status_d == sabo_pkg::ST_OK) && (kind_q != sabo_pkg::KIND_PUSH)
		&& (kind_q <= sabo_pkg::KIND_MOD);
	assign stat.divmod   = kind_q inside {sabo_pkg::KIND_DIV, sabo_pkg::KIND_MOD};
	assign stat.div_done = div_done;

	// only the low word of the product is kept
	assign product = second_q * top_q;

	sabo_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (second_q),
		.divisor   (top_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.decode && push_ok && (count_q != '0)) begin
			mem[cnt_m1[ADDR_W-1:0]] <= top_q;
		end
		if (cmd.decode) begin
			second_q <= mem[cnt_m2[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.decode && push_ok) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			kind_q <= kind;
			push_q <= push_value;
		end
		if (cmd.decode) begin
			status_q <= status_d;
			if (push_ok) begin
				top_q <= push_q;
			end
		end else if (cmd.pop) begin
			top_q <= res_q;
		end
		if (cmd.exec) begin
			case (kind_q)
				sabo_pkg::KIND_ADD: res_q <= second_q + top_q;
				sabo_pkg::KIND_SUB: res_q <= second_q - top_q;
				default:            res_q <= product;
			endcase
		end else if (cmd.div_take) begin
			res_q <= (kind_q == sabo_pkg::KIND_DIV) ? quo : rem;
		end
		if (cmd.out_load) begin
			status_out_q <= status_q;
			top_out_q    <= (count_q != '0) ? top_q : '0;
			depth_out_q  <= count_ext[DW-1:0];
		end
	end

	// depth is reported modulo 128
	assign count_ext = {{DW{1'b0}}, count_q};

	assign status    = status_out_q;
	assign top_value = top_out_q;
	assign depth     = depth_out_q;

endmodule

>>> hw/rtl/stack_alu_binary_ops.sv
// stack_alu_binary_ops: operand stack of signed 32-bit words with push and
// the binary operations add, sub, mul, div and mod (second op top).
// input channel: in_valid/in_ready carry one request of kind and push_value.
// output channel: out_valid/out_ready carry one result per request: status,
// the new top value (zero when empty) and the new depth.
// from acceptance, push, errors and unused kinds go through decode to the
// response; add/sub/mul also pass exec and apply; div/mod wait between exec
// and apply for the 32-step restoring divider.
// throughput: one request at a time; in_ready returns together with out_valid,
// so the next request is only taken once the last result is loaded into the
// output register.
// the top of stack is kept in a register and the rest in a 64-entry memory
// with one read and one write port, so each operation reads the memory once.
// on an error status the stack is left unchanged.
// reset clears the entry count and both handshakes; memory contents need no
// clearing since only entries below the count are used.
// when the receiver stalls, the result waits in the output register, the
// next request is still taken and processed, and it then waits until the
// output register is free.
module stack_alu_binary_ops (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sabo_pkg::KIND_W-1:0]          kind,
	input  logic signed [sabo_pkg::WORD_W-1:0]   push_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sabo_pkg::STATUS_W-1:0]        status,
	output logic signed [sabo_pkg::WORD_W-1:0]   top_value,
	output logic [sabo_pkg::DEPTH_W-1:0]         depth
);

	sabo_pkg::ctrl_cmd_t cmd;
	sabo_pkg::dp_stat_t  stat;

	sabo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sabo_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.push_value (push_value),
		.status     (status),
		.top_value  (top_value),
		.depth      (depth)
	);

endmodule

>>> hw/rtl/sabo_chk.sv
module sabo_chk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [sabo_pkg::KIND_W-1:0]          kind,
	input  logic signed [sabo_pkg::WORD_W-1:0]   push_value,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [sabo_pkg::STATUS_W-1:0]        status,
	input  logic signed [sabo_pkg::WORD_W-1:0]   top_value,
	input  logic [sabo_pkg::DEPTH_W-1:0]         depth
);

	localparam int DW = sabo_pkg::DEPTH_W;
	localparam logic [sabo_pkg::CNT_W+DW-1:0] FULL_EXT =
		(sabo_pkg::CNT_W + DW)'(sabo_pkg::STACK_DEPTH);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_value)
			&& $stable(depth))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth == '0 |-> top_value == '0)
		else $error("nonzero top on empty stack");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sabo_pkg::ST_FULL |-> depth == FULL_EXT[DW-1:0])
		else $error("stack full reported below capacity");

	a_short_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == sabo_pkg::ST_SHORT |-> depth < DW'(2))
		else $error("stack too short reported with two or more entries");

endmodule

bind stack_alu_binary_ops sabo_chk u_sabo_chk (.*);

>>> tb/stack_alu_binary_ops_tb.sv
`timescale 1ns / 100ps

module stack_alu_binary_ops_tb;

	localparam logic [sabo_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [sabo_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic [sabo_pkg::WORD_W-1:0] WORD_MIN      = 32'h8000_0000;
	localparam logic [sabo_pkg::WORD_W-1:0] WORD_MAX      = 32'h7fff_ffff;
	localparam logic [sabo_pkg::WORD_W-1:0] WORD_ALL_ONES = 32'hffff_ffff;
	localparam int                          RANDOM_OPS    = 620;
	localparam int                          SETTLE_CYCLES = 60;

	typedef struct packed {
		logic [sabo_pkg::STATUS_W-1:0] status;
		logic [sabo_pkg::WORD_W-1:0]   top;
		logic [sabo_pkg::DEPTH_W-1:0]  depth;
	} outcome_t;

	typedef struct packed {
		logic [sabo_pkg::KIND_W-1:0] op;
		logic [sabo_pkg::WORD_W-1:0] operand;
		logic                        known;
		outcome_t                    want;
	} script_row_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic [sabo_pkg::KIND_W-1:0]          kind = sabo_pkg::KIND_PUSH;
	logic signed [sabo_pkg::WORD_W-1:0]   push_value = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [sabo_pkg::STATUS_W-1:0]        status;
	logic signed [sabo_pkg::WORD_W-1:0]   top_value;
	logic [sabo_pkg::DEPTH_W-1:0]         depth;

	// typed expectation travelling alongside the request
	logic                                 row_known = 1'b0;
	outcome_t                             row_want = '0;

	logic                                 calm = 1'b0;
	int                                   mismatches = 0;
	outcome_t                             expected_results[$];
	script_row_t                          opening_script[$];

	logic [sabo_pkg::WORD_W-1:0]          model_words[sabo_pkg::STACK_DEPTH];
	int                                   model_count = 0;

	stack_alu_binary_ops DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.top_value  (top_value),
		.depth      (depth)
	);

	always #5 clk = ~clk;

	function automatic outcome_t step_stack_model(input logic [sabo_pkg::KIND_W-1:0] op,
			input logic [sabo_pkg::WORD_W-1:0] operand);
		logic [sabo_pkg::WORD_W-1:0]   tos;
		logic [sabo_pkg::WORD_W-1:0]   nos;
		logic [sabo_pkg::WORD_W-1:0]   mag_tos;
		logic [sabo_pkg::WORD_W-1:0]   mag_nos;
		logic [sabo_pkg::WORD_W-1:0]   res;
		outcome_t                      result;
		result.status = sabo_pkg::ST_OK;
		if (op == sabo_pkg::KIND_PUSH) begin
			if (model_count >= sabo_pkg::STACK_DEPTH) begin
				result.status = sabo_pkg::ST_FULL;
			end else begin
				model_words[model_count] = operand;
				model_count++;
			end
		end else if (op == KIND_SPARE_LO || op == KIND_SPARE_HI) begin
			// unused kinds leave the stack alone
		end else if (model_count < 2) begin
			result.status = sabo_pkg::ST_SHORT;
		end else begin
			tos = model_words[model_count - 1];
			nos = model_words[model_count - 2];
			mag_tos = tos[sabo_pkg::WORD_W-1] ? -tos : tos;
			mag_nos = nos[sabo_pkg::WORD_W-1] ? -nos : nos;
			if ((op == sabo_pkg::KIND_DIV || op == sabo_pkg::KIND_MOD) && tos == '0) begin
				result.status = sabo_pkg::ST_DIVZERO;
			end else begin
				case (op)
					sabo_pkg::KIND_ADD: res = nos + tos;
					sabo_pkg::KIND_SUB: res = nos - tos;
					sabo_pkg::KIND_MUL: res = nos * tos;
					sabo_pkg::KIND_DIV: begin
						// truncate towards zero, sign from both operands
						res = mag_nos / mag_tos;
						if (nos[sabo_pkg::WORD_W-1] ^ tos[sabo_pkg::WORD_W-1])
							res = -res;
					end
					default: begin
						// remainder follows the sign of the dividend
						res = mag_nos % mag_tos;
						if (nos[sabo_pkg::WORD_W-1])
							res = -res;
					end
				endcase
				model_count--;
				model_words[model_count - 1] = res;
			end
		end
		result.top = (model_count > 0) ? model_words[model_count - 1] : '0;
		result.depth = sabo_pkg::DEPTH_W'(model_count);
		return result;
	endfunction

	function automatic logic [sabo_pkg::KIND_W-1:0] pick_binary_op();
		case ($urandom_range(4))
			0: return sabo_pkg::KIND_ADD;
			1: return sabo_pkg::KIND_SUB;
			2: return sabo_pkg::KIND_MUL;
			3: return sabo_pkg::KIND_DIV;
			default: return sabo_pkg::KIND_MOD;
		endcase
	endfunction

	// operands lean towards zero, small magnitudes and the extremes
	function automatic logic [sabo_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return WORD_MIN;
			2: return WORD_MAX;
			3: return WORD_ALL_ONES;
			4: return 32'd1;
			5, 6: return sabo_pkg::WORD_W'(int'($urandom_range(40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(input logic [sabo_pkg::KIND_W-1:0] op,
			input logic [sabo_pkg::WORD_W-1:0] operand,
			input logic known, input logic [sabo_pkg::STATUS_W-1:0] st,
			input logic [sabo_pkg::WORD_W-1:0] top, input logic [sabo_pkg::DEPTH_W-1:0] dep);
		script_row_t r;
		r.op = op;
		r.operand = operand;
		r.known = known;
		r.want.status = st;
		r.want.top = top;
		r.want.depth = dep;
		opening_script.push_back(r);
	endtask

	task automatic send(input logic [sabo_pkg::KIND_W-1:0] op,
			input logic [sabo_pkg::WORD_W-1:0] operand,
			input logic known, input outcome_t want);
		if (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		kind <= op;
		push_value <= operand;
		row_known <= known;
		row_want <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin : watch
		outcome_t want;
		outcome_t got;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: status %0d top %0d depth %0d",
					status, top_value, depth);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (top_value !== want.top) begin
					$error("top_value: expected %0d, got %0d", $signed(want.top), top_value);
					mismatches++;
				end
				if (depth !== want.depth) begin
					$error("depth: expected %0d, got %0d", want.depth, depth);
					mismatches++;
				end
			end
		end
		if (in_valid && in_ready) begin
			got = step_stack_model(kind, push_value);
			expected_results.push_back(row_known ? row_want : got);
		end
	end

	initial begin
		// well past the slowest legal run of about a thousand divides with stalls
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int real_ops;
		int burst;
		int push_odds;
		logic [sabo_pkg::KIND_W-1:0] op;

		add_row(sabo_pkg::KIND_ADD,  '0,            1, sabo_pkg::ST_SHORT,   '0,       7'd0);
		add_row(sabo_pkg::KIND_MOD,  WORD_ALL_ONES, 1, sabo_pkg::ST_SHORT,   '0,       7'd0);
		add_row(sabo_pkg::KIND_PUSH, WORD_MAX,      1, sabo_pkg::ST_OK,      WORD_MAX, 7'd1);
		add_row(sabo_pkg::KIND_SUB,  '0,            1, sabo_pkg::ST_SHORT,   WORD_MAX, 7'd1);
		add_row(sabo_pkg::KIND_PUSH, 32'd1,         1, sabo_pkg::ST_OK,      32'd1,    7'd2);
		add_row(sabo_pkg::KIND_ADD,  '0,            1, sabo_pkg::ST_OK,      WORD_MIN, 7'd1);
		add_row(sabo_pkg::KIND_PUSH, WORD_ALL_ONES, 1, sabo_pkg::ST_OK, WORD_ALL_ONES, 7'd2);
		add_row(sabo_pkg::KIND_DIV,  '0,            1, sabo_pkg::ST_OK,      WORD_MIN, 7'd1);
		add_row(sabo_pkg::KIND_PUSH, WORD_ALL_ONES, 1, sabo_pkg::ST_OK, WORD_ALL_ONES, 7'd2);
		add_row(sabo_pkg::KIND_MOD,  '0,            1, sabo_pkg::ST_OK,      '0,       7'd1);
		add_row(sabo_pkg::KIND_PUSH, '0,            1, sabo_pkg::ST_OK,      '0,       7'd2);
		add_row(sabo_pkg::KIND_DIV,  WORD_ALL_ONES, 1, sabo_pkg::ST_DIVZERO, '0,       7'd2);
		add_row(sabo_pkg::KIND_MOD,  '0,            1, sabo_pkg::ST_DIVZERO, '0,       7'd2);
		add_row(KIND_SPARE_LO,       32'ha5a5_a5a5, 1, sabo_pkg::ST_OK,      '0,       7'd2);
		add_row(KIND_SPARE_HI,       32'h5a5a_5a5a, 1, sabo_pkg::ST_OK,      '0,       7'd2);
		add_row(sabo_pkg::KIND_PUSH, -32'sd7,       0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_PUSH, 32'd2,         0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_DIV,  '0,            0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_PUSH, 32'd2,         0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_MOD,  '0,            0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_PUSH, WORD_MIN,      0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_MUL,  '0,            0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_SUB,  '0,            0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_PUSH, WORD_MAX,      0, sabo_pkg::ST_OK,      '0,       7'd0);
		add_row(sabo_pkg::KIND_ADD,  '0,            0, sabo_pkg::ST_OK,      '0,       7'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_script[i])
			send(opening_script[i].op, opening_script[i].operand,
				opening_script[i].known, opening_script[i].want);

		// sender holds off until the stack unit has answered everything
		wait_drained();

		// fill past the top so full is reported, then drain below two entries
		repeat (sabo_pkg::STACK_DEPTH + 3)
			send(sabo_pkg::KIND_PUSH, pick_word(), 1'b0, '0);
		repeat (sabo_pkg::STACK_DEPTH + 6)
			send(pick_binary_op(), $urandom, 1'b0, '0);

		wait_drained();

		real_ops = 0;
		while (real_ops < RANDOM_OPS) begin
			calm = (real_ops >= 300 && real_ops < 450);
			if ($urandom_range(99) < 4) begin
				op = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
				send(op, $urandom, 1'b0, '0);
			end else if ($urandom_range(99) < 2) begin
				burst = $urandom_range(70, 30);
				repeat (burst)
					send(sabo_pkg::KIND_PUSH, pick_word(), 1'b0, '0);
				real_ops += burst;
			end else begin
				push_odds = (model_count < 2) ? 65 : (model_count > 56) ? 30 : 48;
				if ($urandom_range(99) < push_odds)
					send(sabo_pkg::KIND_PUSH, pick_word(), 1'b0, '0);
				else
					send(pick_binary_op(), $urandom, 1'b0, '0);
				real_ops++;
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sabo_pkg.sv
hw/rtl/sabo_div.sv
hw/rtl/sabo_ctrl.sv
hw/rtl/sabo_dp.sv
hw/rtl/stack_alu_binary_ops.sv
hw/rtl/sabo_chk.sv
tb/stack_alu_binary_ops_tb.sv
